[rtl/core/bcl_pkg.sv]
// Shared types, constants and the preset table for the bias chain loader.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bcl_pkg;

  localparam int NUM_BIASES   = 12;
  localparam int BIAS_BITS    = 24;
  localparam int IDX_W        = 4;
  localparam int PID_W        = 3;
  localparam int OP_W         = 3;
  localparam int BITPTR_W     = 5;
  localparam int PRESET_COUNT = 5;
  localparam int DIGIT_W      = 6;
  localparam int NUM_DIGITS   = 4;
  localparam int DCNT_W       = 2;
  localparam int CHAR_W       = 7;
  localparam int ICHAR_W      = 6;
  localparam int TEXT_BASE    = 32;

  localparam logic [PID_W-1:0] PRESET_RESET = 3'd4;

  localparam logic [OP_W-1:0] OP_SET   = 3'd0;
  localparam logic [OP_W-1:0] OP_GET   = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd2;
  localparam logic [OP_W-1:0] OP_FLUSH = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_BUSY  = 2'd2;

  typedef logic [BIAS_BITS-1:0] bias_word_t;

  localparam bias_word_t PRESET_TABLE [PRESET_COUNT][NUM_BIASES] = '{
    '{24'd1067, 24'd12316, 24'd16777215, 24'd5579731, 24'd60, 24'd427594,
      24'd0, 24'd16777215, 24'd567391, 24'd6831, 24'd39, 24'd4},
    '{24'd1067, 24'd12316, 24'd16777215, 24'd5579732, 24'd151, 24'd427594,
      24'd0, 24'd16777215, 24'd296253, 24'd3624, 24'd39, 24'd4},
    '{24'd1966, 24'd1137667, 24'd16777215, 24'd8053457, 24'd133, 24'd160712,
      24'd944, 24'd16777215, 24'd205255, 24'd3207, 24'd278, 24'd217},
    '{24'd1966, 24'd1135792, 24'd16769632, 24'd8061894, 24'd133, 24'd160703,
      24'd935, 24'd16769632, 24'd205244, 24'd3207, 24'd267, 24'd217},
    '{24'd1966, 24'd1137667, 24'd16777215, 24'd8053458, 24'd62, 24'd160712,
      24'd944, 24'd16777215, 24'd480988, 24'd3207, 24'd278, 24'd217}
  };

  typedef struct packed {
    logic [OP_W-1:0]      opcode;
    logic [IDX_W-1:0]     bias_index;
    logic [BIAS_BITS-1:0] bias_value;
    logic [PID_W-1:0]     preset_id;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [BIAS_BITS-1:0] read_value;
    logic [CHAR_W-1:0]    text_char0;
    logic [CHAR_W-1:0]    text_char1;
    logic [CHAR_W-1:0]    text_char2;
    logic [CHAR_W-1:0]    text_char3;
    logic [ICHAR_W-1:0]   text_index_char;
    logic                 serial_data;
    logic                 clock_pulse;
    logic                 latch_pulse;
    logic                 busy_res;
  } res_item_t;

  // Write and preset-load requests into the bias store.
  typedef struct packed {
    logic                 wr_en;
    logic [IDX_W-1:0]     idx;
    logic [BIAS_BITS-1:0] val;
    logic                 ld_en;
    logic [PID_W-1:0]     pid;
  } store_ctl_t;

  // Pin levels for the current tick and the serializer state after it.
  typedef struct packed {
    logic active;
    logic sdata;
    logic clk_pulse;
    logic latch;
    logic busy_next;
  } flush_stat_t;

  function automatic logic [CHAR_W-1:0] to_char(input logic [DIGIT_W-1:0] d);
    return CHAR_W'(d) + CHAR_W'(TEXT_BASE);
  endfunction

endpackage

[rtl/core/bcl_if.sv]
// Valid/ready channel interfaces for the command and result streams.
// Depends on bcl_pkg for the payload structs.
`timescale 1ns / 1ps

interface bcl_cmd_if import bcl_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bcl_res_if import bcl_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/bcl_store.sv]
// Bias word store: twelve registers, single-word writes, whole-set preset
// loads and one read port. Depends on bcl_pkg.
`timescale 1ns / 1ps

module bcl_store import bcl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  store_ctl_t       ctl,
  input  logic [IDX_W-1:0] rd_addr,
  output bias_word_t       rd_data
);

  bias_word_t bias [NUM_BIASES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BIASES; i++) begin
        bias[i] <= PRESET_TABLE[PRESET_RESET][i];
      end
    end else if (ctl.ld_en) begin
      for (int i = 0; i < NUM_BIASES; i++) begin
        bias[i] <= PRESET_TABLE[ctl.pid][i];
      end
    end else if (ctl.wr_en) begin
      bias[ctl.idx] <= ctl.val;
    end
  end

  // Addresses past the last word read as zero.
  assign rd_data = (rd_addr < IDX_W'(NUM_BIASES)) ? bias[rd_addr] : '0;

endmodule

[rtl/core/bcl_shift.sv]
// Flush serializer: a word-wide shift register that sends one bit per tick,
// most significant first, then a latch strobe. Depends on bcl_pkg.
`timescale 1ns / 1ps

module bcl_shift import bcl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             tick,
  input  bias_word_t       rd_data,
  output logic [IDX_W-1:0] rd_addr,
  output flush_stat_t      stat
);

  logic                active;
  logic                latch_due;
  logic [IDX_W-1:0]    word_pointer;
  logic [BITPTR_W-1:0] bit_pointer;
  bias_word_t          shreg;

  logic shift_now;
  logic word_end;

  assign shift_now = tick && active && !latch_due;
  assign word_end  = (bit_pointer == '0);

  // The next word is fetched while the last bit of the current one leaves.
  assign rd_addr = start ? '0 : word_pointer + IDX_W'(1);

  always_comb begin
    stat.active    = active;
    stat.sdata     = shift_now ? shreg[BIAS_BITS-1] : 1'b0;
    stat.clk_pulse = shift_now;
    stat.latch     = tick && active && latch_due;
    stat.busy_next = start || (active && !(tick && latch_due));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      latch_due    <= 1'b0;
      word_pointer <= '0;
      bit_pointer  <= BITPTR_W'(BIAS_BITS - 1);
    end else if (start) begin
      active       <= 1'b1;
      latch_due    <= 1'b0;
      word_pointer <= '0;
      bit_pointer  <= BITPTR_W'(BIAS_BITS - 1);
      shreg        <= rd_data;
    end else if (tick && active) begin
      if (latch_due) begin
        latch_due <= 1'b0;
        active    <= 1'b0;
      end else if (word_end) begin
        bit_pointer  <= BITPTR_W'(BIAS_BITS - 1);
        word_pointer <= rd_addr;
        shreg        <= rd_data;
        if (rd_addr >= IDX_W'(NUM_BIASES)) begin
          latch_due <= 1'b1;
        end
      end else begin
        bit_pointer <= bit_pointer - BITPTR_W'(1);
        shreg       <= {shreg[BIAS_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/core/bcl_text.sv]
// Text formatter for read-back: takes a word apart one 6-bit digit per cycle
// into printable characters. Depends on bcl_pkg.
`timescale 1ns / 1ps

module bcl_text import bcl_pkg::*; (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  bias_word_t                         word,
  output logic [NUM_DIGITS-1:0][CHAR_W-1:0]  chars,
  output logic                               done
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  bias_word_t        shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == DCNT_W'(NUM_DIGITS - 1));
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        shreg <= word;
      end else if (busy) begin
        chars[cnt] <= to_char(shreg[DIGIT_W-1:0]);
        shreg      <= shreg >> DIGIT_W;
        cnt        <= cnt + DCNT_W'(1);
        if (cnt == DCNT_W'(NUM_DIGITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[rtl/core/bias_chain_loader.sv]
// Bias chain loader top level: command decode, result register and the
// serializer, store and text units. Depends on bcl_pkg, bcl_if, bcl_store,
// bcl_shift and bcl_text.
//
// Usage: commands arrive on the cmd channel and every command produces
// exactly one result on the res channel, in order. A transfer happens when
// valid and ready are both high at a rising clock edge.
// Set, load, start-flush, tick and undefined opcodes finish in the cycle of
// their transfer; the result is registered and appears on res the next
// cycle, and another command may be taken in that same next cycle, so a
// stream of ticks moves one bit of the chain per cycle.
// Get, outside a flush, splits the word into four 6-bit characters one digit per
// cycle in the text unit; its result appears once the text unit is done, and
// cmd is not ready during that time.
// cmd.ready is low whenever the result register is full and res.ready is low,
// so a stalled receiver stops the block without losing results.
// A full flush takes 289 ticks: 288 data bits and one latch strobe.
// Reset (synchronous, rst high) loads preset set four into the store, stops
// any flush and empties the result register.
`timescale 1ns / 1ps

module bias_chain_loader import bcl_pkg::*; (
  input logic     clk,
  input logic     rst,
  bcl_cmd_if.sink   cmd,
  bcl_res_if.source res
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_GET  = 1'b1;

  logic state;
  logic state_next;

  logic        fire;
  logic        idx_ok;
  logic        pid_ok;
  logic        get_go;
  logic        out_valid;
  res_item_t   out_q;
  res_item_t   pend;
  res_item_t   res_next;
  res_item_t   txt_res;
  store_ctl_t  sctl;
  flush_stat_t fstat;
  logic [IDX_W-1:0] flush_addr;
  logic [IDX_W-1:0] rd_addr;
  bias_word_t  rd_data;
  logic [NUM_DIGITS-1:0][CHAR_W-1:0] chars;
  logic        txt_done;

  assign cmd.ready = (state == ST_IDLE) && (!out_valid || res.ready);
  assign fire      = cmd.valid && cmd.ready;
  assign idx_ok    = cmd.item.bias_index < IDX_W'(NUM_BIASES);
  assign pid_ok    = cmd.item.preset_id < PID_W'(PRESET_COUNT);
  assign get_go    = fire && (cmd.item.opcode == OP_GET) && !fstat.active;

  always_comb begin
    sctl.wr_en = fire && (cmd.item.opcode == OP_SET) && !fstat.active && idx_ok;
    sctl.idx   = cmd.item.bias_index;
    sctl.val   = cmd.item.bias_value;
    sctl.ld_en = fire && (cmd.item.opcode == OP_LOAD) && !fstat.active && pid_ok;
    sctl.pid   = cmd.item.preset_id;
  end

  assign rd_addr = get_go ? cmd.item.bias_index : flush_addr;

  bcl_store u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (sctl),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bcl_shift u_shift (
    .clk     (clk),
    .rst     (rst),
    .start   (fire && (cmd.item.opcode == OP_FLUSH) && !fstat.active),
    .tick    (fire && (cmd.item.opcode == OP_TICK)),
    .rd_data (rd_data),
    .rd_addr (flush_addr),
    .stat    (fstat)
  );

  bcl_text u_text (
    .clk   (clk),
    .rst   (rst),
    .start (get_go),
    .word  (rd_data),
    .chars (chars),
    .done  (txt_done)
  );

  always_comb begin
    res_next                 = '0;
    res_next.text_char0      = CHAR_W'(TEXT_BASE);
    res_next.text_char1      = CHAR_W'(TEXT_BASE);
    res_next.text_char2      = CHAR_W'(TEXT_BASE);
    res_next.text_char3      = CHAR_W'(TEXT_BASE);
    res_next.text_index_char = ICHAR_W'(TEXT_BASE);
    res_next.serial_data     = fstat.sdata;
    res_next.clock_pulse     = fstat.clk_pulse;
    res_next.latch_pulse     = fstat.latch;
    res_next.busy_res        = fstat.busy_next;
    if (cmd.item.opcode != OP_TICK) begin
      priority if (fstat.active) begin
        res_next.status = STAT_BUSY;
      end else if (cmd.item.opcode == OP_SET || cmd.item.opcode == OP_GET) begin
        res_next.status = idx_ok ? STAT_OK : STAT_RANGE;
      end else if (cmd.item.opcode == OP_LOAD) begin
        res_next.status = pid_ok ? STAT_OK : STAT_RANGE;
      end else begin
        res_next.status = STAT_OK;
      end
      if (!fstat.active && cmd.item.opcode == OP_GET) begin
        res_next.text_index_char = ICHAR_W'(cmd.item.bias_index) + ICHAR_W'(TEXT_BASE);
        // The store reads zero past the last word.
        res_next.read_value      = rd_data;
      end
    end
  end

  always_comb begin
    txt_res            = pend;
    txt_res.text_char0 = chars[0];
    txt_res.text_char1 = chars[1];
    txt_res.text_char2 = chars[2];
    txt_res.text_char3 = chars[3];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (get_go) state_next = ST_GET;
      ST_GET:  if (txt_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (get_go) begin
        pend <= res_next;
        // The result register is drained by this transfer; it stays empty
        // until the characters are ready.
        if (res.ready) out_valid <= 1'b0;
      end else if (fire) begin
        out_q     <= res_next;
        out_valid <= 1'b1;
      end else if (txt_done) begin
        out_q     <= txt_res;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_q;

  a_no_accept_in_get: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GET) |-> !cmd.ready)
    else $error("command taken while a read-back is being formatted");

  a_done_only_in_get: assert property (@(posedge clk) disable iff (rst)
    txt_done |-> (state == ST_GET) && !out_valid)
    else $error("text unit finished outside a read-back or over a full result");

  a_pins_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_q.clock_pulse && out_q.latch_pulse))
    else $error("clock and latch pulses in one result");

  a_latch_ends_flush: assert property (@(posedge clk) disable iff (rst)
    (fire && fstat.latch) |=> !fstat.active)
    else $error("serializer still active after the latch strobe");

  a_store_quiet_in_flush: assert property (@(posedge clk) disable iff (rst)
    fstat.active |-> !sctl.wr_en && !sctl.ld_en)
    else $error("store changed while a flush is in progress");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for bias_chain_loader: drives the command channel,
// predicts every response and checks each one as it is transferred.
// Depends on bcl_pkg, bcl_if and the bias_chain_loader RTL.
`timescale 1ns / 1ps

module tb_top;
  import bcl_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam int PLAN_ITEMS  = 1150;
  localparam int CHAIN_TICKS = NUM_BIASES * BIAS_BITS + 1;
  localparam int CALM_TAIL   = 150;
  localparam int DRAIN_CYCLES = 20;

  localparam bias_word_t BIAS_PRESETS [PRESET_COUNT][NUM_BIASES] = '{
    '{24'd1067, 24'd12316, 24'd16777215, 24'd5579731, 24'd60, 24'd427594,
      24'd0, 24'd16777215, 24'd567391, 24'd6831, 24'd39, 24'd4},
    '{24'd1067, 24'd12316, 24'd16777215, 24'd5579732, 24'd151, 24'd427594,
      24'd0, 24'd16777215, 24'd296253, 24'd3624, 24'd39, 24'd4},
    '{24'd1966, 24'd1137667, 24'd16777215, 24'd8053457, 24'd133, 24'd160712,
      24'd944, 24'd16777215, 24'd205255, 24'd3207, 24'd278, 24'd217},
    '{24'd1966, 24'd1135792, 24'd16769632, 24'd8061894, 24'd133, 24'd160703,
      24'd935, 24'd16769632, 24'd205244, 24'd3207, 24'd267, 24'd217},
    '{24'd1966, 24'd1137667, 24'd16777215, 24'd8053458, 24'd62, 24'd160712,
      24'd944, 24'd16777215, 24'd480988, 24'd3207, 24'd278, 24'd217}
  };

  logic clk;
  logic rst;

  bcl_cmd_if cmd_ch ();
  bcl_res_if res_ch ();

  bias_chain_loader DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // Mirror of the bias store and the serializer.
  bias_word_t bias_mirror [NUM_BIASES];
  bit         chain_flushing;
  bit         chain_latch_due;
  int         chain_word;
  int         chain_bit;

  cmd_item_t command_plan [$];
  res_item_t pending_responses [$];

  bit cmd_waiting;
  bit no_idle;
  int send_gap;
  int recv_stall;
  int cycle_count;
  int error_count;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void load_preset(input int id);
    for (int i = 0; i < NUM_BIASES; i++) begin
      bias_mirror[i] = BIAS_PRESETS[id][i];
    end
  endfunction

  function automatic res_item_t chain_response(input cmd_item_t c);
    res_item_t  r;
    bias_word_t word;
    r = '0;
    word = '0;
    r.text_index_char = ICHAR_W'(TEXT_BASE);
    if (c.opcode == OP_TICK) begin
      if (chain_flushing) begin
        if (chain_latch_due) begin
          r.latch_pulse = 1'b1;
          chain_latch_due = 1'b0;
          chain_flushing = 1'b0;
        end else begin
          r.serial_data = bias_mirror[chain_word][chain_bit];
          r.clock_pulse = 1'b1;
          if (chain_bit == 0) begin
            chain_bit = BIAS_BITS - 1;
            chain_word++;
            if (chain_word >= NUM_BIASES) chain_latch_due = 1'b1;
          end else begin
            chain_bit--;
          end
        end
      end
    end else if (chain_flushing) begin
      r.status = STAT_BUSY;
    end else begin
      case (c.opcode)
        OP_SET: begin
          if (c.bias_index < NUM_BIASES) bias_mirror[c.bias_index] = c.bias_value;
          else r.status = STAT_RANGE;
        end
        OP_GET: begin
          r.text_index_char = ICHAR_W'(c.bias_index) + ICHAR_W'(TEXT_BASE);
          if (c.bias_index < NUM_BIASES) word = bias_mirror[c.bias_index];
          else r.status = STAT_RANGE;
        end
        OP_LOAD: begin
          if (c.preset_id < PRESET_COUNT) load_preset(c.preset_id);
          else r.status = STAT_RANGE;
        end
        OP_FLUSH: begin
          chain_flushing = 1'b1;
          chain_latch_due = 1'b0;
          chain_word = 0;
          chain_bit = BIAS_BITS - 1;
        end
        default: begin
        end
      endcase
    end
    r.read_value = word;
    r.text_char0 = CHAR_W'(word[5:0]) + CHAR_W'(TEXT_BASE);
    r.text_char1 = CHAR_W'(word[11:6]) + CHAR_W'(TEXT_BASE);
    r.text_char2 = CHAR_W'(word[17:12]) + CHAR_W'(TEXT_BASE);
    r.text_char3 = CHAR_W'(word[23:18]) + CHAR_W'(TEXT_BASE);
    r.busy_res = chain_flushing;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic cmd_item_t make_cmd(input logic [OP_W-1:0] op, input int idx,
                                         input int value, input int pid);
    cmd_item_t c;
    c.opcode = op;
    c.bias_index = IDX_W'(idx);
    c.bias_value = BIAS_BITS'(value);
    c.preset_id = PID_W'(pid);
    return c;
  endfunction

  function automatic cmd_item_t random_command();
    cmd_item_t c;
    int pick;
    c.bias_index = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(NUM_BIASES, 15))
                                                : IDX_W'($urandom_range(0, NUM_BIASES - 1));
    case ($urandom_range(0, 7))
      0: c.bias_value = '0;
      1: c.bias_value = '1;
      default: c.bias_value = BIAS_BITS'($urandom);
    endcase
    c.preset_id = PID_W'($urandom_range(0, 7));
    pick = $urandom_range(0, 19);
    if (pick < 6) c.opcode = OP_SET;
    else if (pick < 12) c.opcode = OP_GET;
    else if (pick < 15) c.opcode = OP_LOAD;
    else if (pick < 18) c.opcode = OP_TICK;
    else if (pick == 18) c.opcode = OP_FLUSH;
    else c.opcode = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    return c;
  endfunction

  // Ticks with random contents in the unused fields, and now and then a
  // stray command that the block must refuse while it is flushing.
  task automatic push_flush_ticks(input int count);
    cmd_item_t c;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        command_plan.push_back(random_command());
      end else begin
        c = random_command();
        c.opcode = OP_TICK;
        command_plan.push_back(c);
      end
    end
  endtask

  // Monitor: predicts on each command transfer and checks each response.
  always @(posedge clk) begin
    res_item_t want;
    res_item_t got;
    if (!rst) begin
      cycle_count++;
      if (cycle_count % 256 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (command_plan.size() < CALM_TAIL) no_idle = 1'b1;
      if (cmd_ch.valid && cmd_ch.ready) begin
        pending_responses.push_back(chain_response(cmd_ch.item));
        cmd_waiting = 1'b0;
      end
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (pending_responses.size() == 0) begin
          $error("response transferred with none expected");
          error_count++;
        end else begin
          want = pending_responses.pop_front();
          check_field("status", want.status, got.status);
          check_field("read_value", want.read_value, got.read_value);
          check_field("text_char0", want.text_char0, got.text_char0);
          check_field("text_char1", want.text_char1, got.text_char1);
          check_field("text_char2", want.text_char2, got.text_char2);
          check_field("text_char3", want.text_char3, got.text_char3);
          check_field("text_index_char", want.text_index_char, got.text_index_char);
          check_field("serial_data", want.serial_data, got.serial_data);
          check_field("clock_pulse", want.clock_pulse, got.clock_pulse);
          check_field("latch_pulse", want.latch_pulse, got.latch_pulse);
          check_field("busy_res", want.busy_res, got.busy_res);
        end
      end
    end
  end

  // Command driver.
  always @(negedge clk) begin
    if (!rst && !cmd_waiting) begin
      if (send_gap > 0) begin
        cmd_ch.valid <= 1'b0;
        send_gap--;
      end else if (command_plan.size() == 0) begin
        cmd_ch.valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        cmd_ch.valid <= 1'b0;
        send_gap = $urandom_range(1, 7) - 1;
      end else begin
        cmd_ch.item <= command_plan.pop_front();
        cmd_ch.valid <= 1'b1;
        cmd_waiting = 1'b1;
      end
    end
  end

  // Response sink with random back-pressure.
  always @(negedge clk) begin
    if (!rst) begin
      if (recv_stall > 0) begin
        res_ch.ready <= 1'b0;
        recv_stall--;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        res_ch.ready <= 1'b0;
        recv_stall = $urandom_range(1, 7) - 1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.item = '0;
    res_ch.ready = 1'b0;
    cmd_waiting = 1'b0;
    no_idle = 1'b0;
    send_gap = 0;
    recv_stall = 0;
    cycle_count = 0;
    error_count = 0;

    load_preset(PRESET_RESET);
    chain_flushing = 1'b0;
    chain_latch_due = 1'b0;
    chain_word = 0;
    chain_bit = BIAS_BITS - 1;

    // Directed part: reset contents, range limits, every opcode, and
    // commands refused while a flush is running.
    command_plan.push_back(make_cmd(OP_GET, 0, 0, 0));
    command_plan.push_back(make_cmd(OP_GET, NUM_BIASES - 1, 0, 0));
    command_plan.push_back(make_cmd(OP_GET, NUM_BIASES, 0, 0));
    command_plan.push_back(make_cmd(OP_GET, 15, 0, 0));
    command_plan.push_back(make_cmd(OP_SET, 0, 24'hFFFFFF, 7));
    command_plan.push_back(make_cmd(OP_SET, NUM_BIASES - 1, 0, 0));
    command_plan.push_back(make_cmd(OP_SET, 15, 24'hA5A5A5, 0));
    command_plan.push_back(make_cmd(OP_GET, 0, 0, 0));
    command_plan.push_back(make_cmd(OP_GET, NUM_BIASES - 1, 0, 0));
    command_plan.push_back(make_cmd(OP_LOAD, 0, 0, 7));
    command_plan.push_back(make_cmd(OP_LOAD, 0, 0, PRESET_COUNT));
    command_plan.push_back(make_cmd(OP_LOAD, 0, 0, 0));
    command_plan.push_back(make_cmd(OP_GET, 3, 0, 0));
    command_plan.push_back(make_cmd(OP_TICK, 15, 24'hFFFFFF, 7));
    command_plan.push_back(make_cmd(OP_SPARE_FIRST, 0, 0, 0));
    command_plan.push_back(make_cmd(OP_SPARE_FIRST + 3'd1, 5, 0, 3));
    command_plan.push_back(make_cmd(OP_SPARE_LAST, 15, 24'hFFFFFF, 7));
    command_plan.push_back(make_cmd(OP_FLUSH, 0, 0, 0));
    command_plan.push_back(make_cmd(OP_TICK, 0, 0, 0));
    command_plan.push_back(make_cmd(OP_SET, 1, 24'h123456, 0));
    command_plan.push_back(make_cmd(OP_GET, 1, 0, 0));
    command_plan.push_back(make_cmd(OP_LOAD, 0, 0, 2));
    command_plan.push_back(make_cmd(OP_FLUSH, 0, 0, 0));
    command_plan.push_back(make_cmd(OP_SPARE_LAST, 0, 0, 0));
    command_plan.push_back(make_cmd(OP_TICK, 0, 0, 0));

    // Finish the flush begun above, then mix command bursts with flushes.
    push_flush_ticks(CHAIN_TICKS + 2);
    while (command_plan.size() < PLAN_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        command_plan.push_back(random_command());
        command_plan[command_plan.size() - 1].opcode = OP_FLUSH;
        // Now and then a flush is cut short and the next burst meets it.
        if ($urandom_range(0, 4) == 0) push_flush_ticks($urandom_range(20, 100));
        else push_flush_ticks(CHAIN_TICKS + $urandom_range(0, 4));
      end else begin
        repeat ($urandom_range(8, 30)) command_plan.push_back(random_command());
      end
    end
    while (command_plan.size() > PLAN_ITEMS) begin
      void'(command_plan.pop_back());
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
    end while (command_plan.size() != 0 || cmd_waiting || pending_responses.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
